// ===== rtl/core/i2a_pkg.sv =====
// shared constants, types and sizing functions of the integer to ascii formatter
`default_nettype none
package i2a_pkg;

	localparam int VALUE_BITS_DEF  = 32;
	localparam int STEPS_PER_STAGE = 8;

	// format opcodes
	localparam logic [1:0] OP_UDEC = 2'd0;
	localparam logic [1:0] OP_SDEC = 2'd1;
	localparam logic [1:0] OP_HEXL = 2'd2;
	localparam logic [1:0] OP_HEXU = 2'd3;

	// ascii codes
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_TEN     = 8'd10;

	typedef struct packed {
		logic hex;
		logic upper;
		logic neg;
	} fmt_t;

	// decimal digits of 2^w - 1 (1233 / 4096 ~ log10(2))
	function automatic int dec_digits(input int w);
		return ((w * 1233) >> 12) + 1;
	endfunction

	function automatic int nibble_digits(input int w);
		return (w + 3) >> 2;
	endfunction

	function automatic int num_digits(input int w);
		return (dec_digits(w) > nibble_digits(w)) ? dec_digits(w) : nibble_digits(w);
	endfunction

	function automatic int num_stages(input int w);
		return (w + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/i2a_front.sv =====
// entry stage: format decode and two's-complement magnitude
`default_nettype none
module i2a_front import i2a_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire logic                  leave,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic [1:0]            opcode,
	output logic                       valid_s1,
	output fmt_t                       fmt_s1,
	output logic [num_stages(VALUE_BITS)*STEPS_PER_STAGE-1:0] bin_s1
);

	localparam int PW = num_stages(VALUE_BITS) * STEPS_PER_STAGE;

	fmt_t                  fmt_d;
	logic [VALUE_BITS-1:0] mag_d;

	always_comb begin
		fmt_d.hex   = (opcode == OP_HEXL) || (opcode == OP_HEXU);
		fmt_d.upper = (opcode == OP_HEXU);
		fmt_d.neg   = (opcode == OP_SDEC) && value[VALUE_BITS-1];
		// most negative value negates to itself, which is the right magnitude
		mag_d       = fmt_d.neg ? (~value + 1'b1) : value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (leave) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fmt_s1 <= fmt_d;
			bin_s1 <= PW'(mag_d);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/i2a_dd_stage.sv =====
// one shift-and-add-3 stage, several bits per stage; plain shift in hex mode
`default_nettype none
module i2a_dd_stage import i2a_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire logic leave,
	input  wire fmt_t in_fmt,
	input  wire logic [num_stages(VALUE_BITS)*STEPS_PER_STAGE-1:0] in_bin,
	input  wire logic [num_digits(VALUE_BITS)*4-1:0]               in_bcd,
	output logic      valid_sn,
	output fmt_t      fmt_sn,
	output logic [num_stages(VALUE_BITS)*STEPS_PER_STAGE-1:0] bin_sn,
	output logic [num_digits(VALUE_BITS)*4-1:0]               bcd_sn
);

	localparam int PW  = num_stages(VALUE_BITS) * STEPS_PER_STAGE;
	localparam int DIG = num_digits(VALUE_BITS);
	localparam int BW  = DIG * 4;

	logic [PW-1:0] bin_nx;
	logic [BW-1:0] bcd_nx;

	always_comb begin
		bin_nx = in_bin;
		bcd_nx = in_bcd;
		for (int k = 0; k < STEPS_PER_STAGE; k++) begin
			for (int d = 0; d < DIG; d++) begin
				if (!in_fmt.hex && (bcd_nx[d*4 +: 4] >= 4'd5)) begin
					bcd_nx[d*4 +: 4] = bcd_nx[d*4 +: 4] + 4'd3;
				end
			end
			bcd_nx = {bcd_nx[BW-2:0], bin_nx[PW-1]};
			bin_nx = bin_nx << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (load) begin
			valid_sn <= 1'b1;
		end else if (leave) begin
			valid_sn <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fmt_sn <= in_fmt;
			bin_sn <= bin_nx;
			bcd_sn <= bcd_nx;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/i2a_emit.sv =====
// character serializer: sign, leading zero skip, then one character per cycle
`default_nettype none
module i2a_emit import i2a_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire fmt_t in_fmt,
	input  wire logic [num_digits(VALUE_BITS)*4-1:0] in_bcd,
	output logic      take,
	output logic      strobe,
	output logic [7:0] char_out,
	output logic      last
);

	localparam int DIG   = num_digits(VALUE_BITS);
	localparam int ND    = dec_digits(VALUE_BITS);
	localparam int NH    = nibble_digits(VALUE_BITS);
	localparam int POS_W = $clog2(DIG);

	logic             active_q;
	logic             sign_q;
	logic             started_q;
	logic             upper_q;
	logic [POS_W-1:0] pos_q;
	logic [3:0]       dig_q [DIG];

	logic [3:0] digit;
	logic [7:0] dchar;
	logic       skip;
	logic       emit;
	logic       fin;

	always_comb begin
		digit = dig_q[pos_q];
		if (digit < 4'd10) begin
			dchar = CH_ZERO + {4'b0, digit};
		end else begin
			dchar = (upper_q ? CH_UPPER_A : CH_LOWER_A) + {4'b0, digit} - CH_TEN;
		end
		skip = active_q && !sign_q && !started_q && (digit == 4'd0) && (pos_q != '0);
		emit = active_q && !skip;
		fin  = active_q && !sign_q && !skip && (pos_q == '0);
		take = in_valid && (!active_q || fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			sign_q    <= 1'b0;
			started_q <= 1'b0;
			strobe    <= 1'b0;
		end else begin
			strobe <= emit;
			if (take) begin
				active_q  <= 1'b1;
				sign_q    <= in_fmt.neg;
				started_q <= 1'b0;
			end else if (active_q) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (fin) begin
					active_q <= 1'b0;
				end else if (!skip) begin
					started_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		char_out <= sign_q ? CH_MINUS : dchar;
		last     <= fin;
		if (take) begin
			upper_q <= in_fmt.upper;
			pos_q   <= in_fmt.hex ? POS_W'(NH - 1) : POS_W'(ND - 1);
			for (int d = 0; d < DIG; d++) begin
				dig_q[d] <= in_bcd[d*4 +: 4];
			end
		end else if (active_q && !sign_q && !fin) begin
			pos_q <= pos_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/integer_to_ascii_formatter_top.sv =====
// top level of the integer to ascii formatter
// path: entry stage, then conversion stages of 8 bits each, then the serializer,
//   which skips leading zeros before the first character
// throughput: the serializer steps one digit position per cycle, skipped zeros included,
//   plus one step for a minus sign, and takes the next item as it finishes the last;
//   conversion overlaps in the pipe
// reset: arst_n clears all valid bits and the serializer's control and strobe; payload registers keep no reset
// the receiver cannot stall: each character is shown for exactly one cycle with strobe
`default_nettype none
module integer_to_ascii_formatter_top import i2a_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic [1:0]            opcode,
	output logic                       strobe,
	output logic [7:0]                 char_out,
	output logic                       last
);

	localparam int NSTG = num_stages(VALUE_BITS);
	localparam int PW   = NSTG * STEPS_PER_STAGE;
	localparam int BW   = num_digits(VALUE_BITS) * 4;

	// index 0 is the entry stage, 1..NSTG the conversion stages
	logic          st_valid [NSTG+1];
	logic          st_adv   [NSTG+1];
	fmt_t          st_fmt   [NSTG+1];
	logic [PW-1:0] st_bin   [NSTG+1];
	logic [BW-1:0] st_bcd   [NSTG+1];

	logic em_take;
	logic load;

	// entry stage blocks only when it holds an item that cannot move on
	assign busy = st_valid[0] && !st_adv[0];
	assign load = start && !busy;

	i2a_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.leave   (st_adv[0]),
		.value   (value),
		.opcode  (opcode),
		.valid_s1(st_valid[0]),
		.fmt_s1  (st_fmt[0]),
		.bin_s1  (st_bin[0])
	);

	// bcd accumulator starts empty
	assign st_bcd[0] = '0;

	// an item moves on when the next stage is empty or moving on itself;
	// the last stage moves on when the serializer takes it
	genvar g;
	generate
		for (g = 0; g < NSTG; g++) begin : g_adv
			assign st_adv[g] = st_valid[g] && (!st_valid[g+1] || st_adv[g+1]);
		end
	endgenerate
	assign st_adv[NSTG] = st_valid[NSTG] && em_take;

	// conversion pipe: each stage shifts in a group of bits, adding 3 to any
	// decimal digit of 5 or more before each shift; hex items shift plainly
	generate
		for (g = 1; g <= NSTG; g++) begin : g_stage
			i2a_dd_stage #(
				.VALUE_BITS(VALUE_BITS)
			) u_stage (
				.clk     (clk),
				.arst_n  (arst_n),
				.load    (st_adv[g-1]),
				.leave   (st_adv[g]),
				.in_fmt  (st_fmt[g-1]),
				.in_bin  (st_bin[g-1]),
				.in_bcd  (st_bcd[g-1]),
				.valid_sn(st_valid[g]),
				.fmt_sn  (st_fmt[g]),
				.bin_sn  (st_bin[g]),
				.bcd_sn  (st_bcd[g])
			);
		end
	endgenerate

	// serializer: optional '-', skips leading zeros, then one character per cycle
	i2a_emit #(
		.VALUE_BITS(VALUE_BITS)
	) u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(st_valid[NSTG]),
		.in_fmt  (st_fmt[NSTG]),
		.in_bcd  (st_bcd[NSTG]),
		.take    (em_take),
		.strobe  (strobe),
		.char_out(char_out),
		.last    (last)
	);

endmodule
`default_nettype wire

// ===== rtl/core/i2a_checker.sv =====
// port-level checks of the integer to ascii formatter and their bind
`default_nettype none
module i2a_checker import i2a_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       strobe,
	input wire logic [7:0] char_out,
	input wire logic       last
);

	// last only marks a shown character
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last without strobe");

	// a sign is never the final character
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (char_out == CH_MINUS)) |-> !last)
		else $error("minus sign marked last");

	// only digits, hex letters or a minus sign come out
	a_char_class: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((char_out >= 8'h30) && (char_out <= 8'h39))
			|| ((char_out >= 8'h41) && (char_out <= 8'h46))
			|| ((char_out >= 8'h61) && (char_out <= 8'h66))
			|| (char_out == CH_MINUS))
		else $error("unexpected character");

	// busy can only rise right after an item was offered
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose with no item offered");

endmodule

bind integer_to_ascii_formatter_top i2a_checker u_i2a_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.strobe  (strobe),
	.char_out(char_out),
	.last    (last)
);
`default_nettype wire

// ===== tb/tb_integer_to_ascii_formatter_top.sv =====
// self-checking testbench of the integer to ascii formatter top level
`timescale 1ns / 1ps
`default_nettype none
module tb_integer_to_ascii_formatter_top import i2a_pkg::*;;

	localparam int VALUE_BITS = VALUE_BITS_DEF;
	// longest correct stretch without a take or a character is a sender gap plus a
	// full conversion; this is many times that
	localparam int STALL_LIMIT = 4000;
	// first character comes once the item has passed the pipe and its leading zeros are skipped
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_ITEMS = 85;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_last;
	} char_rec_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [VALUE_BITS-1:0] value;
	logic [1:0]            opcode;
	logic                  strobe;
	logic [7:0]            char_out;
	logic                  last;

	// characters still owed by the block, oldest first
	char_rec_t expected_chars[$];
	int        err_count  = 0;
	int        idle_count = 0;
	int        burst_left = 0;

	integer_to_ascii_formatter_top #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.value   (value),
		.opcode  (opcode),
		.strobe  (strobe),
		.char_out(char_out),
		.last    (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor: the ascii text of one number, most significant first
	// ------------------------------------------------------------------
	function automatic void format_chars(input logic [VALUE_BITS-1:0] num,
			input logic [1:0] op);
		bit [7:0]  digits[0:23];
		int        n;
		int        i;
		bit        started;
		bit [3:0]  nib;
		bit [63:0] mag;
		char_rec_t rec;
		n = 0;
		started = 1'b0;
		mag = 64'(num);
		if (op == OP_HEXL || op == OP_HEXU) begin
			for (i = (VALUE_BITS + 3) / 4 - 1; i >= 0; i--) begin
				nib = 4'(mag >> (i * 4));
				// leading zero nibbles are dropped, the lowest one never
				if (!started && nib == 4'd0 && i != 0)
					continue;
				started = 1'b1;
				if (nib < 4'd10)
					rec.ch = CH_ZERO + 8'(nib);
				else if (op == OP_HEXU)
					rec.ch = CH_UPPER_A + 8'(nib - 4'd10);
				else
					rec.ch = CH_LOWER_A + 8'(nib - 4'd10);
				rec.is_last = (i == 0);
				expected_chars.push_back(rec);
			end
		end else begin
			if (op == OP_SDEC && num[VALUE_BITS-1]) begin
				// two's complement at the block width; the most negative value
				// comes out as 2^(w-1) since mag is wider than the value
				mag = 64'(VALUE_BITS'(-num));
				if (mag == 64'd0)
					mag = 64'd1 << (VALUE_BITS - 1);
				rec.ch = CH_MINUS;
				rec.is_last = 1'b0;
				expected_chars.push_back(rec);
			end
			do begin
				digits[n] = CH_ZERO + 8'(mag % 64'd10);
				n++;
				mag = mag / 64'd10;
			end while (mag != 64'd0);
			while (n > 0) begin
				n--;
				rec.ch = digits[n];
				rec.is_last = (n == 0);
				expected_chars.push_back(rec);
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// sender side: called at a falling edge, returns at a falling edge
	// ------------------------------------------------------------------
	task automatic send_item(input logic [VALUE_BITS-1:0] v, input logic [1:0] op);
		start  = 1'b1;
		value  = v;
		opcode = op;
		// busy is seen as it stood just before the edge
		do
			@(posedge clk);
		while (busy);
		format_chars(v, op);
		@(negedge clk);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			start = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// bursts of back-to-back items, most of them separated by random gaps
	task automatic pace_sender();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 24));
		end
		burst_left--;
	endtask

	// hold off until the block has delivered everything owed
	task automatic wait_drained();
		start = 1'b0;
		while (expected_chars.size() != 0)
			@(negedge clk);
	endtask

	// random number with a shape picked so that every digit count shows up
	function automatic logic [VALUE_BITS-1:0] random_value();
		bit [63:0] v;
		bit [63:0] p;
		int        k;
		case ($urandom_range(0, 6))
			0: v = 64'($urandom_range(0, 99));
			1: begin
				k = $urandom_range(1, VALUE_BITS);
				v = 64'($urandom) & ((64'd1 << k) - 64'd1);
			end
			2: begin
				// straddle a power of ten
				p = 64'd1;
				repeat ($urandom_range(1, 9)) p = p * 64'd10;
				v = p + 64'($urandom_range(0, 2)) - 64'd1;
			end
			3: v = 64'(-$urandom_range(1, 1000));
			4: begin
				// whole leading nibbles of zero
				k = 4 * $urandom_range(1, 7);
				v = 64'($urandom) >> k;
			end
			default: v = 64'($urandom);
		endcase
		return v[VALUE_BITS-1:0];
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_zero();
		send_item('0, OP_UDEC);
		send_item('0, OP_SDEC);
		send_item('0, OP_HEXL);
		send_item('0, OP_HEXU);
	endtask

	task automatic test_extremes();
		send_item('1, OP_UDEC);
		send_item('1, OP_SDEC);
		send_item('1, OP_HEXL);
		send_item('1, OP_HEXU);
		// most negative: magnitude printed in full
		send_item(VALUE_BITS'(1) << (VALUE_BITS - 1), OP_SDEC);
		send_item(VALUE_BITS'(1) << (VALUE_BITS - 1), OP_UDEC);
		send_item((VALUE_BITS'(1) << (VALUE_BITS - 1)) + 1'b1, OP_SDEC);
		send_item(~(VALUE_BITS'(1) << (VALUE_BITS - 1)), OP_SDEC);
		send_item(VALUE_BITS'(1), OP_SDEC);
		send_item(VALUE_BITS'(9), OP_UDEC);
		send_item(VALUE_BITS'(10), OP_UDEC);
		send_item(VALUE_BITS'(1000000000), OP_UDEC);
	endtask

	task automatic test_hex_case();
		send_item(VALUE_BITS'(32'hABCDEF01), OP_HEXL);
		send_item(VALUE_BITS'(32'hABCDEF01), OP_HEXU);
		send_item(VALUE_BITS'(32'h0000000F), OP_HEXL);
		send_item(VALUE_BITS'(32'hF0000000), OP_HEXU);
		send_item(VALUE_BITS'(32'h00FEDCBA), OP_HEXL);
		send_item(VALUE_BITS'(32'h10000000), OP_HEXU);
	endtask

	// sender waits for a full drain, then restarts from an empty pipe
	task automatic test_drain_pause();
		wait_drained();
		send_item(VALUE_BITS'(32'h12345678), OP_HEXU);
		wait_drained();
		send_item(VALUE_BITS'(-7), OP_SDEC);
		send_item(VALUE_BITS'(0), OP_HEXL);
	endtask

	task automatic test_random();
		int i;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pace_sender();
			// now and then let the pipe run dry mid-stream
			if ($urandom_range(0, 29) == 0)
				wait_drained();
			send_item(random_value(), 2'($urandom_range(0, 3)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		opcode = OP_UDEC;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_zero();
		test_extremes();
		test_hex_case();
		test_drain_pause();
		test_random();

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_chars.size() != 0) begin
			$display("%0t: %0d characters never arrived", $realtime, expected_chars.size());
			err_count += expected_chars.size();
		end
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// result checker: every strobed character against the oldest owed one
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		char_rec_t want;
		if (arst_n && strobe) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected char expected none actual %h last %b",
					$realtime, char_out, last);
				err_count++;
			end else begin
				want = expected_chars.pop_front();
				if (char_out !== want.ch) begin
					$display("%0t: char_out expected %h actual %h",
						$realtime, want.ch, char_out);
					err_count++;
				end
				if (last !== want.is_last) begin
					$display("%0t: last expected %b actual %b",
						$realtime, want.is_last, last);
					err_count++;
				end
			end
		end
	end

	// watchdog: too long with neither a take nor a character ends the run
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

endmodule
`default_nettype wire
